// ===== design/bei_pkg.sv =====
// ----------------------------------------------------------------------------
// bei_pkg
// shared constants, types and helper functions of the bit error injector
// ----------------------------------------------------------------------------
`default_nettype none

package bei_pkg;

	localparam int unsigned DRAWS     = 8;
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned LEN_W     = 10;
	localparam int unsigned CNT_W     = 4;

	localparam logic [WORD_W-1:0] SEED_FALLBACK   = 64'h853c49e6748fea9b;
	localparam logic [WORD_W-1:0] BURST_THR_RESET = 64'h7fffffffffffffff;
	localparam logic [WORD_W-1:0] BG_THR_RESET    = 64'h0;
	localparam logic [LEN_W-1:0]  BURST_MIN_LEN   = 10'd10;

	localparam logic [CFG_IDX_W-1:0] REG_BG_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BU_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [DRAWS-1:0][WORD_W-1:0] draw_set_t;
	typedef logic [2*DRAWS-1:0][WORD_W-1:0] draw_chain_t;

	function automatic word_t xs_step(input word_t x);
		word_t y;
		y = x ^ (x << 13);
		y = y ^ (y >> 7);
		y = y ^ (y << 17);
		return y;
	endfunction

	function automatic logic [CNT_W-1:0] popcount8(input logic [DRAWS-1:0] v);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < DRAWS; i++) begin
			c = c + {{(CNT_W-1){1'b0}}, v[i]};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/bei_ifs.sv =====
// ----------------------------------------------------------------------------
// bei interfaces
// valid/ready channels for input bytes, result bytes and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface bei_in_if;
	logic                           valid;
	logic                           ready;
	logic [7:0]                     data_byte;
	logic                           start_burst;
	logic [bei_pkg::LEN_W-1:0]      burst_length;

	modport source (output valid, output data_byte, output start_burst,
		output burst_length, input ready);
	modport sink (input valid, input data_byte, input start_burst,
		input burst_length, output ready);
endinterface

interface bei_out_if;
	logic                           valid;
	logic                           ready;
	logic [7:0]                     out_byte;
	logic [bei_pkg::CNT_W-1:0]      background_flips;
	logic [bei_pkg::CNT_W-1:0]      burst_flips;
	logic                           in_burst;

	modport source (output valid, output out_byte, output background_flips,
		output burst_flips, output in_burst, input ready);
	modport sink (input valid, input out_byte, input background_flips,
		input burst_flips, input in_burst, output ready);
endinterface

interface bei_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bei_pkg::CFG_IDX_W-1:0]  index;
	logic [bei_pkg::WORD_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/bit_error_injector.sv =====
// ----------------------------------------------------------------------------
// bit_error_injector
// Corrupts a byte stream with background and burst bit errors drawn from a
// 64-bit xorshift generator. One byte is taken per cycle unless the output
// side stalls; its result is registered in the draw stage, then passes the
// compare stage into the output register and waits there until taken. The
// sustained rate of one byte per cycle is set by the generator update loop,
// which advances the state by zero, eight or sixteen chained xorshift steps
// within the cycle of the input transfer. Register writes take effect at once
// and are accepted in every cycle; a seed write reloads the generator, a zero
// seed is replaced by the fixed fallback constant.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_error_injector (
	input  wire         clk,
	input  wire         arst_n,
	bei_in_if.sink      din,
	bei_out_if.source   dout,
	bei_cfg_if.sink     cfg
);

	bei_pkg::word_t                 bg_thr_q;
	bei_pkg::word_t                 bu_thr_q;
	bei_pkg::word_t                 state_q;
	logic [bei_pkg::LEN_W-1:0]      burst_left_q;

	bei_pkg::draw_chain_t           chain;
	logic [bei_pkg::LEN_W-1:0]      req_len;
	logic [bei_pkg::LEN_W-1:0]      bl_eff;
	logic                           bg_on;
	logic                           bu_on;
	logic                           in_xfer;
	logic                           s1_move;

	logic                           valid_s1;
	logic [7:0]                     data_s1;
	logic                           bg_on_s1;
	logic                           bu_on_s1;
	bei_pkg::draw_set_t             bg_draw_s1;
	bei_pkg::draw_set_t             bu_draw_s1;

	logic [bei_pkg::DRAWS-1:0]      bg_hit;
	logic [bei_pkg::DRAWS-1:0]      bu_hit;

	logic                           out_valid_q;
	logic [7:0]                     out_byte_q;
	logic [bei_pkg::CNT_W-1:0]      bg_flips_q;
	logic [bei_pkg::CNT_W-1:0]      bu_flips_q;
	logic                           in_burst_q;

	bei_draw_gen u_draw_gen (
		.state (state_q),
		.chain (chain)
	);

	// burst start, generator usage
	assign req_len = (din.burst_length < bei_pkg::BURST_MIN_LEN) ?
		bei_pkg::BURST_MIN_LEN : din.burst_length;
	assign bl_eff  = (din.start_burst && (burst_left_q == '0)) ? req_len : burst_left_q;
	assign bg_on   = (bg_thr_q != '0);
	assign bu_on   = (bl_eff != '0);

	// handshakes
	assign s1_move   = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || s1_move;
	assign in_xfer   = din.valid && din.ready;
	assign cfg.ready = 1'b1;

	// config registers and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_thr_q     <= bei_pkg::BG_THR_RESET;
			bu_thr_q     <= bei_pkg::BURST_THR_RESET;
			state_q      <= bei_pkg::SEED_FALLBACK;
			burst_left_q <= '0;
		end else begin
			if (in_xfer) begin
				if (bg_on && bu_on) begin
					state_q <= chain[2*bei_pkg::DRAWS-1];
				end else if (bg_on || bu_on) begin
					state_q <= chain[bei_pkg::DRAWS-1];
				end
				burst_left_q <= bu_on ? (bl_eff - 10'd1) : bl_eff;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					bei_pkg::REG_BG_THR: begin
						bg_thr_q <= cfg.data;
					end
					bei_pkg::REG_BU_THR: begin
						bu_thr_q <= cfg.data;
					end
					bei_pkg::REG_SEED: begin
						state_q <= (cfg.data == '0) ? bei_pkg::SEED_FALLBACK : cfg.data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// draw stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1    <= din.data_byte;
			bg_on_s1   <= bg_on;
			bu_on_s1   <= bu_on;
			bg_draw_s1 <= chain[bei_pkg::DRAWS-1:0];
			bu_draw_s1 <= bg_on ? chain[2*bei_pkg::DRAWS-1:bei_pkg::DRAWS] :
				chain[bei_pkg::DRAWS-1:0];
		end
	end

	// compare stage
	always_comb begin
		for (int i = 0; i < bei_pkg::DRAWS; i++) begin
			bg_hit[i] = bg_on_s1 && (bg_draw_s1[i] < bg_thr_q);
			bu_hit[i] = bu_on_s1 && (bu_draw_s1[i] < bu_thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_byte_q <= data_s1 ^ bg_hit ^ bu_hit;
			bg_flips_q <= bei_pkg::popcount8(bg_hit);
			bu_flips_q <= bei_pkg::popcount8(bu_hit);
			in_burst_q <= bu_on_s1;
		end
	end

	assign dout.valid            = out_valid_q;
	assign dout.out_byte         = out_byte_q;
	assign dout.background_flips = bg_flips_q;
	assign dout.burst_flips      = bu_flips_q;
	assign dout.in_burst         = in_burst_q;

	// checks
	a_state_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != '0)
		else $error("generator state reached zero");

	a_burst_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && din.start_burst && (burst_left_q == '0) |=> burst_left_q >= 10'd9)
		else $error("burst start loaded a short length");

	a_no_burst_flips: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !in_burst_q |-> bu_flips_q == '0)
		else $error("burst flips outside a burst");

	a_bg_off: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && !bg_on_s1 |=> bg_flips_q == '0)
		else $error("background flips with background draws off");

endmodule

`default_nettype wire

// ===== design/bei_draw_gen.sv =====
// ----------------------------------------------------------------------------
// bei_draw_gen
// sixteen consecutive xorshift draws from the current generator state
// ----------------------------------------------------------------------------
`default_nettype none

module bei_draw_gen (
	input  wire bei_pkg::word_t       state,
	output bei_pkg::draw_chain_t      chain
);

	assign chain[0] = bei_pkg::xs_step(state);

	for (genvar i = 1; i < 2 * bei_pkg::DRAWS; i++) begin : g_step
		assign chain[i] = bei_pkg::xs_step(chain[i-1]);
	end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed bytes through the bit error injector while the
// register channel reprograms thresholds and seed between phases. A local
// xorshift predictor tracks generator state and burst length, and each result
// transfer is checked field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------

module testbench;

	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          RAND_PHASES  = 9;
	localparam int          PHASE_BYTES  = 54;
	localparam logic [bei_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam bei_pkg::word_t ALL_ONES  = {bei_pkg::WORD_W{1'b1}};

	typedef enum logic [1:0] {STEP_BYTE, STEP_REG_WRITE, STEP_DRAIN} plan_kind_t;

	typedef struct packed {
		plan_kind_t                        kind;
		logic [7:0]                        data_byte;
		logic                              start_burst;
		logic [bei_pkg::LEN_W-1:0]         burst_length;
		logic [bei_pkg::CFG_IDX_W-1:0]     reg_index;
		bei_pkg::word_t                    reg_data;
		int                                gap;
		logic                              hold_mark;
	} plan_step_t;

	typedef struct packed {
		logic [7:0]                        out_byte;
		logic [bei_pkg::CNT_W-1:0]         bg_flips;
		logic [bei_pkg::CNT_W-1:0]         bu_flips;
		logic                              in_burst;
	} flip_result_t;

	logic clk = 1'b0;
	logic arst_n;

	bei_in_if  in_ch ();
	bei_out_if out_ch ();
	bei_cfg_if reg_ch ();

	bit_error_injector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (in_ch),
		.dout   (out_ch),
		.cfg    (reg_ch)
	);

	always #1 clk = ~clk;

	// predictor state
	bei_pkg::word_t            bg_thr;
	bei_pkg::word_t            bu_thr;
	bei_pkg::word_t            gen_state;
	logic [bei_pkg::LEN_W-1:0] burst_left;

	plan_step_t   plan_q[$];
	flip_result_t corrupted_q[$];

	plan_step_t   cur;
	plan_step_t   offered;
	bit           have_cur;
	bit           byte_busy;
	bit           write_busy;
	int           gap_left;
	logic         offer_hold;

	flip_result_t want;
	int           rx_stall_left;
	int           rx_calm_left;
	int           hold_left;
	int           cycle_count = 0;

	int           errors = 0;
	int           bytes_sent = 0;
	int           burst_results = 0;
	int           bg_flip_total = 0;
	int           bu_flip_total = 0;
	int           reg_writes = 0;
	int           results_seen = 0;

	function automatic bei_pkg::word_t gen_next();
		bei_pkg::word_t x;
		x = gen_state;
		x = x ^ (x << 13);
		x = x ^ (x >> 7);
		x = x ^ (x << 17);
		gen_state = x;
		return x;
	endfunction

	function automatic flip_result_t corrupt_byte(input plan_step_t s);
		flip_result_t r;
		logic [7:0]   b;
		r = '0;
		b = s.data_byte;
		if (s.start_burst && burst_left == '0) begin
			burst_left = (s.burst_length < bei_pkg::BURST_MIN_LEN) ?
				bei_pkg::BURST_MIN_LEN : s.burst_length;
		end
		if (bg_thr != '0) begin
			for (int i = 0; i < 8; i++) begin
				if (gen_next() < bg_thr) begin
					b[i] = ~b[i];
					r.bg_flips = r.bg_flips + 1'b1;
				end
			end
		end
		if (burst_left != '0) begin
			for (int i = 0; i < 8; i++) begin
				if (gen_next() < bu_thr) begin
					b[i] = ~b[i];
					r.bu_flips = r.bu_flips + 1'b1;
				end
			end
			burst_left = burst_left - 1'b1;
			r.in_burst = 1'b1;
		end
		r.out_byte = b;
		return r;
	endfunction

	function automatic void apply_reg_write(input logic [bei_pkg::CFG_IDX_W-1:0] idx,
		input bei_pkg::word_t val);
		case (idx)
			bei_pkg::REG_BG_THR: bg_thr = val;
			bei_pkg::REG_BU_THR: bu_thr = val;
			bei_pkg::REG_SEED: gen_state = (val == '0) ? bei_pkg::SEED_FALLBACK : val;
			default: ;
		endcase
	endfunction

	function automatic void plan_byte(input logic [7:0] b, input logic s,
		input logic [bei_pkg::LEN_W-1:0] len, input int gap, input logic hold);
		plan_step_t p;
		p = '0;
		p.kind = STEP_BYTE;
		p.data_byte = b;
		p.start_burst = s;
		p.burst_length = len;
		p.gap = gap;
		p.hold_mark = hold;
		plan_q.push_back(p);
	endfunction

	function automatic void plan_write(input logic [bei_pkg::CFG_IDX_W-1:0] idx,
		input bei_pkg::word_t val);
		plan_step_t p;
		p = '0;
		p.kind = STEP_REG_WRITE;
		p.reg_index = idx;
		p.reg_data = val;
		plan_q.push_back(p);
	endfunction

	function automatic void plan_drain();
		plan_step_t p;
		p = '0;
		p.kind = STEP_DRAIN;
		plan_q.push_back(p);
	endfunction

	function automatic bei_pkg::word_t pick_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ALL_ONES;
			2: return 64'd1;
			3: return {$urandom, $urandom};
			default: return {$urandom, $urandom} >> $urandom_range(1, 12);
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= '0;
			in_ch.start_burst <= 1'b0;
			in_ch.burst_length <= '0;
			reg_ch.valid <= 1'b0;
			reg_ch.index <= '0;
			reg_ch.data <= '0;
			offer_hold <= 1'b0;
			have_cur = 1'b0;
			byte_busy = 1'b0;
			write_busy = 1'b0;
			gap_left = 0;
			bg_thr = bei_pkg::BG_THR_RESET;
			bu_thr = bei_pkg::BURST_THR_RESET;
			gen_state = bei_pkg::SEED_FALLBACK;
			burst_left = '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				corrupted_q.push_back(corrupt_byte(offered));
				bytes_sent++;
				byte_busy = 1'b0;
			end
			if (reg_ch.valid && reg_ch.ready) begin
				apply_reg_write(offered.reg_index, offered.reg_data);
				reg_writes++;
				write_busy = 1'b0;
			end
			if (!byte_busy && !write_busy) begin
				if (!have_cur && plan_q.size() != 0) begin
					cur = plan_q.pop_front();
					have_cur = 1'b1;
					gap_left = cur.gap;
				end
				if (have_cur) begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						case (cur.kind)
							STEP_BYTE: begin
								offered = cur;
								in_ch.data_byte <= cur.data_byte;
								in_ch.start_burst <= cur.start_burst;
								in_ch.burst_length <= cur.burst_length;
								offer_hold <= cur.hold_mark;
								byte_busy = 1'b1;
								have_cur = 1'b0;
							end
							STEP_REG_WRITE: begin
								if (corrupted_q.size() == 0) begin
									offered = cur;
									reg_ch.index <= cur.reg_index;
									reg_ch.data <= cur.reg_data;
									write_busy = 1'b1;
									have_cur = 1'b0;
								end
							end
							default: begin
								if (corrupted_q.size() == 0) have_cur = 1'b0;
							end
						endcase
					end
				end
			end
			in_ch.valid <= byte_busy;
			reg_ch.valid <= write_busy;
		end
	end

	// long receiver hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (in_ch.valid && in_ch.ready && offer_hold) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_stall_left = 0;
			rx_calm_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (corrupted_q.size() == 0) begin
					$error("result transfer with nothing expected: out_byte %0h", out_ch.out_byte);
					errors++;
				end else begin
					want = corrupted_q.pop_front();
					if (out_ch.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
						errors++;
					end
					if (out_ch.background_flips !== want.bg_flips) begin
						$error("background_flips: expected %0d, got %0d",
							want.bg_flips, out_ch.background_flips);
						errors++;
					end
					if (out_ch.burst_flips !== want.bu_flips) begin
						$error("burst_flips: expected %0d, got %0d",
							want.bu_flips, out_ch.burst_flips);
						errors++;
					end
					if (out_ch.in_burst !== want.in_burst) begin
						$error("in_burst: expected %0d, got %0d", want.in_burst, out_ch.in_burst);
						errors++;
					end
					bg_flip_total += want.bg_flips;
					bu_flip_total += want.bu_flips;
					burst_results += want.in_burst;
				end
				if (rx_calm_left > 0) begin
					rx_calm_left--;
					rx_stall_left = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					rx_calm_left = $urandom_range(10, 40);
					rx_stall_left = 0;
				end else begin
					rx_stall_left = $urandom_range(0, 18);
				end
			end else if (rx_stall_left != 0) begin
				rx_stall_left--;
			end
			out_ch.ready <= (rx_stall_left == 0) && (hold_left == 0);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				corrupted_q.size());
			$display("** bit_error_injector: FAILED **");
			$finish;
		end
	end

	initial begin
		bit calm;
		int gap;
		arst_n = 1'b0;

		// reset settings: no background, half-rate bursts
		plan_byte(8'h00, 1'b0, '0, 0, 1'b0);
		plan_byte(8'hff, 1'b0, 10'h3ff, 0, 1'b0);
		plan_byte(8'h5a, 1'b1, 10'd0, 0, 1'b0);
		plan_byte(8'ha5, 1'b1, 10'd1023, 0, 1'b0);
		for (int k = 0; k < 8; k++) begin
			plan_byte(8'(k * 37), (k == 3), 10'd9, 0, 1'b0);
		end
		plan_byte(8'hc3, 1'b1, 10'd9, 0, 1'b0);

		// full background rate, zero burst rate, zero seed
		plan_write(bei_pkg::REG_BG_THR, ALL_ONES);
		plan_write(bei_pkg::REG_BU_THR, '0);
		plan_write(bei_pkg::REG_SEED, '0);
		plan_byte(8'hff, 1'b0, '0, 0, 1'b0);
		plan_byte(8'h00, 1'b0, '0, 0, 1'b0);

		// minimal background rate, full burst rate, seed of one, unused register index
		plan_write(bei_pkg::REG_BG_THR, 64'd1);
		plan_write(bei_pkg::REG_BU_THR, ALL_ONES);
		plan_write(bei_pkg::REG_SEED, 64'd1);
		plan_write(REG_UNUSED, {$urandom, $urandom});
		for (int k = 0; k < 3; k++) begin
			plan_byte(8'($urandom_range(0, 255)), 1'b1, 10'd1023, 0, 1'b0);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0 || $urandom_range(0, 2) != 0) begin
				plan_write(bei_pkg::REG_BG_THR, pick_threshold());
			end
			if (ph == 0 || $urandom_range(0, 2) != 0) begin
				plan_write(bei_pkg::REG_BU_THR, pick_threshold());
			end
			if (ph == 0 || $urandom_range(0, 2) != 0) begin
				plan_write(bei_pkg::REG_SEED,
					($urandom_range(0, 5) == 0) ? '0 : {$urandom, $urandom});
			end
			if ($urandom_range(0, 4) == 0) plan_write(REG_UNUSED, {$urandom, $urandom});
			calm = (ph % 4 == 1);
			for (int k = 0; k < PHASE_BYTES; k++) begin
				if (calm) gap = 0;
				else gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
				plan_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 24) == 0),
					($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
						: 10'($urandom_range(0, 30)),
					gap, (ph == 1 && k == 5));
				if (!calm && $urandom_range(0, 40) == 0) plan_drain();
			end
			plan_drain();
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (plan_q.size() != 0 || have_cur || byte_busy || write_busy
			|| corrupted_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (corrupted_q.size() != 0) begin
			$error("%0d predicted results never arrived", corrupted_q.size());
			errors++;
		end
		$display("sent %0d bytes and checked %0d results, %0d of them inside bursts",
			bytes_sent, results_seen, burst_results);
		$display("%0d register writes, %0d background and %0d burst bit flips, %0d errors",
			reg_writes, bg_flip_total, bu_flip_total, errors);
		if (errors == 0) begin
			$display("** bit_error_injector: PASSED **");
		end else begin
			$display("** bit_error_injector: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/bei_pkg.sv
design/bei_ifs.sv
design/bei_draw_gen.sv
design/bit_error_injector.sv
bench/testbench.sv
